FILE: rtl/core/icmp_prm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the ICMP probe reply matcher.
// No dependencies; imported by icmp_probe_reply_matcher_unit.
package icmp_prm_pkg;

    localparam int unsigned MAX_DATAGRAM = 2048;
    localparam int unsigned CNT_W        = $clog2(MAX_DATAGRAM + 1);
    localparam int unsigned POS_W        = $clog2(MAX_DATAGRAM);

    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned PADDR_W   = 3;

    localparam logic [7:0] ICMP_ECHO_REPLY    = 8'd0;
    localparam logic [7:0] ICMP_ECHO_REQUEST  = 8'd8;
    localparam logic [7:0] ICMP_TIME_EXCEEDED = 8'd11;
    localparam logic [3:0] IP_VERSION_4       = 4'h4;

    localparam logic REG_PROBE_IDENT = 1'b0;
    localparam logic REG_DEST_ADDR   = 1'b1;

    localparam logic KIND_ECHO_REPLY    = 1'b0;
    localparam logic KIND_TIME_EXCEEDED = 1'b1;

    typedef enum logic [1:0] {
        ST_OURS      = 2'd0,
        ST_SHORT     = 2'd1,
        ST_NOT_PROBE = 2'd2,
        ST_FOREIGN   = 2'd3
    } t_status;

    // Fields captured for one choice of ICMP start offset
    typedef struct packed {
        logic [7:0]  msg_type;
        logic [5:0]  ihl;
        logic [7:0]  inner_type;
        logic [15:0] id_echo;
        logic [15:0] seq_echo;
        logic [15:0] id_inner;
        logic [15:0] seq_inner;
    } t_cand;

    // Per-datagram state frozen on the last byte
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             v4;
        logic [5:0]       ohl;
        t_cand            cand0;
        t_cand            cand1;
        logic [7:0]       seq;
        logic [31:0]      from;
    } t_snap;

endpackage

FILE: rtl/core/icmp_probe_reply_matcher_unit.sv
`timescale 1ns / 1ps
// ICMP probe reply matcher: byte-stream parser, id/seq match, APB config.
// Depends on icmp_prm_pkg.
//
// channel | dir | transaction          | fields (lsb first)
// s_axis  | in  | one datagram byte    | tdata: rx_byte, expected_seq, sender_addr; tlast
// m_axis  | out | one match result     | tdata: match_status, reached_dest, reply_from;
//         |     |                      | tuser: reply_kind
// apb     | in  | register write/read  | 0x0 probe_ident, 0x4 dest_addr
//
// One byte per cycle while not stalled. After its last byte is accepted, a result passes the input
// register and snapshot register and is presented from the result register; it can leave on the next edge.
// The stages advance together; they stall only while a result sits unread in the
// output register. Reset is synchronous and clears all control and live per-datagram state.
module icmp_probe_reply_matcher_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [icmp_prm_pkg::S_TDATA_W-1:0] s_axis_tdata,  // rx_byte, expected_seq, sender_addr
    input  logic                              s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [icmp_prm_pkg::M_TDATA_W-1:0] m_axis_tdata,  // match_status, reached_dest,
                                                              // reply_from, zero pad
    output logic                              m_axis_tuser,   // reply_kind
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [icmp_prm_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import icmp_prm_pkg::*;

    function automatic t_cand f_capture(t_cand cur, logic [POS_W-1:0] rel, logic [7:0] b);
        t_cand            nx;
        logic [5:0]       ihl;
        logic [POS_W:0]   base;
        logic [POS_W:0]   k;
        nx = cur;
        if (rel == POS_W'(0)) begin
            nx.msg_type = b;
        end else if (rel == POS_W'(4) || rel == POS_W'(5)) begin
            nx.id_echo = {cur.id_echo[7:0], b};
        end else if (rel == POS_W'(6) || rel == POS_W'(7)) begin
            nx.seq_echo = {cur.seq_echo[7:0], b};
        end
        ihl = (rel == POS_W'(8)) ? {b[3:0], 2'b00} : cur.ihl;
        nx.ihl = ihl;
        base = (POS_W+1)'(8) + (POS_W+1)'(ihl);
        k    = {1'b0, rel} - base;
        if (rel >= POS_W'(8) && {1'b0, rel} >= base) begin
            if (k == (POS_W+1)'(0)) begin
                nx.inner_type = b;
            end else if (k == (POS_W+1)'(4) || k == (POS_W+1)'(5)) begin
                nx.id_inner = {cur.id_inner[7:0], b};
            end else if (k == (POS_W+1)'(6) || k == (POS_W+1)'(7)) begin
                nx.seq_inner = {cur.seq_inner[7:0], b};
            end
        end
        return nx;
    endfunction

    // configuration
    logic [15:0] r_probe_ident;
    logic [31:0] r_dest_addr;
    logic        cfg_wr;

    // input register
    logic        r_in_vld;
    logic        r_in_last;
    logic [7:0]  r_in_byte;
    logic [7:0]  r_in_seq;
    logic [31:0] r_in_from;

    // live per-datagram state
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_v4,   n_v4;
    logic [5:0]       r_ohl,  n_ohl;
    t_cand            r_cand0, n_cand0;
    t_cand            r_cand1, n_cand1;

    // snapshot of the finished datagram
    logic  r_fin_vld;
    t_snap r_fin;

    // result register
    logic        r_out_vld;
    t_status     r_out_status, n_out_status;
    logic        r_out_kind,   n_out_kind;
    logic        r_out_reached, n_out_reached;
    logic [31:0] r_out_from;

    logic             en;
    logic             proc;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] rel1;
    logic             v4_eff;
    logic [5:0]       ohl_eff;

    assign en            = !r_out_vld || m_axis_tready;
    assign s_axis_tready = en;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_DEST_ADDR) ? r_dest_addr : {16'd0, r_probe_ident};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe_ident <= 16'd1;
            r_dest_addr   <= 32'd0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_PROBE_IDENT) begin
                r_probe_ident <= pwdata[15:0];
            end else begin
                r_dest_addr <= pwdata;
            end
        end
    end

    // ---------------- input register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (en) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_byte <= s_axis_tdata[7:0];
            r_in_seq  <= s_axis_tdata[15:8];
            r_in_from <= s_axis_tdata[47:16];
            r_in_last <= s_axis_tlast;
        end
    end

    // ---------------- parse stage ----------------
    // bytes past the size limit are dropped; the count saturates there
    assign proc    = r_in_vld && (r_cnt < CNT_W'(MAX_DATAGRAM));
    assign pos     = r_cnt[POS_W-1:0];
    assign v4_eff  = (pos == POS_W'(0)) ? (r_in_byte[7:4] == IP_VERSION_4) : r_v4;
    assign ohl_eff = (pos == POS_W'(0)) ? (v4_eff ? {r_in_byte[3:0], 2'b00} : 6'd0) : r_ohl;
    assign rel1    = pos - POS_W'(ohl_eff);

    always_comb begin
        n_cnt   = r_cnt;
        n_v4    = r_v4;
        n_ohl   = r_ohl;
        n_cand0 = r_cand0;
        n_cand1 = r_cand1;
        if (proc) begin
            n_cnt   = r_cnt + CNT_W'(1);
            n_v4    = v4_eff;
            n_ohl   = ohl_eff;
            n_cand0 = f_capture(r_cand0, pos, r_in_byte);
            if (v4_eff && pos >= POS_W'(ohl_eff)) begin
                n_cand1 = f_capture(r_cand1, rel1, r_in_byte);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_v4      <= 1'b0;
            r_ohl     <= '0;
            r_cand0   <= '0;
            r_cand1   <= '0;
            r_fin_vld <= 1'b0;
        end else if (en) begin
            r_fin_vld <= r_in_vld && r_in_last;
            if (r_in_vld && r_in_last) begin
                r_cnt   <= '0;
                r_v4    <= 1'b0;
                r_ohl   <= '0;
                r_cand0 <= '0;
                r_cand1 <= '0;
            end else begin
                r_cnt   <= n_cnt;
                r_v4    <= n_v4;
                r_ohl   <= n_ohl;
                r_cand0 <= n_cand0;
                r_cand1 <= n_cand1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_in_vld && r_in_last) begin
            r_fin.cnt   <= n_cnt;
            r_fin.v4    <= n_v4;
            r_fin.ohl   <= n_ohl;
            r_fin.cand0 <= n_cand0;
            r_fin.cand1 <= n_cand1;
            r_fin.seq   <= r_in_seq;
            r_fin.from  <= r_in_from;
        end
    end

    // ---------------- decision stage ----------------
    logic             use_ip;
    logic [CNT_W-1:0] msg_len;
    t_cand            sel;
    logic [15:0]      rid;
    logic [15:0]      rseq;
    logic             have;

    always_comb begin
        use_ip = r_fin.v4 && r_fin.cnt >= CNT_W'(20)
                 && r_fin.cnt >= CNT_W'(r_fin.ohl) + CNT_W'(8);
        msg_len       = r_fin.cnt - (use_ip ? CNT_W'(r_fin.ohl) : CNT_W'(0));
        sel           = use_ip ? r_fin.cand1 : r_fin.cand0;
        rid           = 16'd0;
        rseq          = 16'd0;
        have          = 1'b0;
        n_out_kind    = KIND_ECHO_REPLY;
        n_out_reached = 1'b0;
        n_out_status  = ST_NOT_PROBE;
        if (msg_len < CNT_W'(8)) begin
            n_out_status = ST_SHORT;
        end else begin
            if (sel.msg_type == ICMP_TIME_EXCEEDED) begin
                n_out_kind = KIND_TIME_EXCEEDED;
            end
            if (sel.msg_type == ICMP_ECHO_REPLY) begin
                rid  = sel.id_echo;
                rseq = sel.seq_echo;
                have = 1'b1;
            end else if (sel.msg_type == ICMP_TIME_EXCEEDED) begin
                // quoted header plus 8 bytes of the original echo request must fit
                if (msg_len < CNT_W'(36) || msg_len < CNT_W'(sel.ihl) + CNT_W'(16)) begin
                    n_out_status = ST_SHORT;
                end else if (sel.inner_type == ICMP_ECHO_REQUEST) begin
                    rid  = sel.id_inner;
                    rseq = sel.seq_inner;
                    have = 1'b1;
                end
            end
            if (have) begin
                if (rid == r_probe_ident && rseq == {8'd0, r_fin.seq}) begin
                    n_out_status  = ST_OURS;
                    n_out_reached = (sel.msg_type == ICMP_ECHO_REPLY)
                                    && (r_fin.from == r_dest_addr);
                end else begin
                    n_out_status = ST_FOREIGN;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_fin_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_fin_vld) begin
            r_out_status  <= n_out_status;
            r_out_kind    <= n_out_kind;
            r_out_reached <= n_out_reached;
            r_out_from    <= r_fin.from;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {5'd0, r_out_from, r_out_reached, r_out_status};

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DATAGRAM))
        else $error("byte count beyond datagram limit");

    a_reached_ours: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_reached |-> r_out_status == ST_OURS && r_out_kind == KIND_ECHO_REPLY)
        else $error("destination flagged on a reply that is not our echo reply");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_in_vld && r_in_last |=> r_cnt == '0 && !r_v4)
        else $error("datagram state not cleared after last byte");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        en && r_fin_vld |=> r_out_vld)
        else $error("finished datagram produced no result");

endmodule
